### rtl/cms_pkg.sv
`default_nettype none
package cms_pkg;

    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_HEIGHT  = 128;
    localparam int DEF_STACK_DEPTH = 4;

    localparam int POS_W   = 10;
    localparam int COV_W   = 8;
    localparam int COLOR_W = 32;
    localparam int VIEW_W_W = 9;
    localparam int VIEW_H_W = 8;
    localparam int CFG_W   = 9;
    localparam int CFG_IDX_W = 1;
    // wide enough for view compares at the largest plane size
    localparam int CMP_W   = 12;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_APPLY = 2'd1;
    localparam logic [1:0] CMD_POP   = 2'd2;
    localparam logic [1:0] CMD_PIXEL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_VIEW_W = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_H = 1'b1;

    localparam logic [VIEW_W_W-1:0] RESET_VIEW_W = 9'd256;
    localparam logic [VIEW_H_W-1:0] RESET_VIEW_H = 8'd128;

    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_ACK = 1'b1;

    // round(a*b/255) = (a*b + 127) / 255, divide done as reciprocal multiply
    localparam logic [16:0] ROUND       = 17'd127;
    localparam logic [16:0] RECIP       = 17'h08081;
    localparam int          RECIP_SHIFT = 23;

    typedef struct packed {
        logic [1:0] cmd;
        logic       in_view;
        logic       span_end;
    } t_ctl;

endpackage
`default_nettype wire

### rtl/cms_ram.sv
`default_nettype none
module cms_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr_a,
    input  wire logic [AW-1:0] i_raddr_b,
    output logic      [W-1:0]  o_rdata_a,
    output logic      [W-1:0]  o_rdata_b
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

### rtl/cms_outq.sv
`default_nettype none
module cms_outq #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr,
    input  wire logic [W-1:0] i_wdata,
    input  wire logic         i_pop,
    output logic              o_empty,
    output logic              o_room2,
    output logic      [W-1:0] o_data
);

    localparam int DEPTH = 4;

    logic [W-1:0] r_slot [DEPTH];
    logic [1:0]   r_wptr;
    logic [1:0]   r_rptr;
    logic [2:0]   r_cnt;
    logic         take;

    assign o_empty = (r_cnt == 3'd0);
    assign o_room2 = (r_cnt <= 3'(DEPTH - 2));
    assign o_data  = r_slot[r_rptr];
    assign take    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wptr] <= i_wdata;
        end
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr) r_wptr <= r_wptr + 2'd1;
            if (take) r_rptr <= r_rptr + 2'd1;
            r_cnt <= r_cnt + 3'(i_wr) - 3'(take);
        end
    end

endmodule
`default_nettype wire

### rtl/cms_front.sv
`default_nettype none
module cms_front
    import cms_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int XW = $clog2(MAX_WIDTH),
    parameter int YW = $clog2(MAX_HEIGHT)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    output logic                      o_full,
    input  wire logic [1:0]           i_command,
    input  wire logic [POS_W-1:0]     i_row,
    input  wire logic [POS_W-1:0]     i_column,
    input  wire logic [COV_W-1:0]     i_coverage,
    input  wire logic [COLOR_W-1:0]   i_color,
    input  wire logic                 i_span_end,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output logic                      o_valid,
    input  wire logic                 i_take,
    output t_ctl                      o_ctl,
    output logic      [XW-1:0]        o_x,
    output logic      [YW-1:0]        o_y,
    output logic      [COV_W-1:0]     o_cov,
    output logic      [COLOR_W-1:0]   o_color
);

    logic [VIEW_W_W-1:0] r_view_w;
    logic [VIEW_H_W-1:0] r_view_h;

    t_ctl               r_q_ctl   [2];
    logic [XW-1:0]      r_q_x     [2];
    logic [YW-1:0]      r_q_y     [2];
    logic [COV_W-1:0]   r_q_cov   [2];
    logic [COLOR_W-1:0] r_q_color [2];
    logic               r_wptr;
    logic               r_rptr;
    logic [1:0]         r_cnt;

    logic [CMP_W-1:0] eff_w;
    logic [CMP_W-1:0] eff_h;
    logic             row_ok;
    logic             col_ok;
    logic             acc;
    logic             take;
    t_ctl             cls;

    // view saturated to 1..max
    always_comb begin
        if (r_view_w == '0) eff_w = CMP_W'(1);
        else if (CMP_W'(r_view_w) > CMP_W'(MAX_WIDTH)) eff_w = CMP_W'(MAX_WIDTH);
        else eff_w = CMP_W'(r_view_w);
        if (r_view_h == '0) eff_h = CMP_W'(1);
        else if (CMP_W'(r_view_h) > CMP_W'(MAX_HEIGHT)) eff_h = CMP_W'(MAX_HEIGHT);
        else eff_h = CMP_W'(r_view_h);
    end

    assign row_ok = !i_row[POS_W-1] && (CMP_W'(i_row[POS_W-2:0]) < eff_h);
    assign col_ok = !i_column[POS_W-1] && (CMP_W'(i_column[POS_W-2:0]) < eff_w);

    assign cls.cmd      = i_command;
    assign cls.in_view  = row_ok && col_ok;
    assign cls.span_end = i_span_end;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign acc     = i_push && !o_full;
    assign take    = i_take && o_valid;

    assign o_ctl   = r_q_ctl[r_rptr];
    assign o_x     = r_q_x[r_rptr];
    assign o_y     = r_q_y[r_rptr];
    assign o_cov   = r_q_cov[r_rptr];
    assign o_color = r_q_color[r_rptr];

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q_ctl[r_wptr]   <= cls;
            r_q_x[r_wptr]     <= XW'(i_column[POS_W-2:0]);
            r_q_y[r_wptr]     <= YW'(i_row[POS_W-2:0]);
            r_q_cov[r_wptr]   <= i_coverage;
            r_q_color[r_wptr] <= i_color;
        end
        if (!i_rst_n) begin
            r_wptr   <= 1'b0;
            r_rptr   <= 1'b0;
            r_cnt    <= '0;
            r_view_w <= RESET_VIEW_W;
            r_view_h <= RESET_VIEW_H;
        end else begin
            if (acc)  r_wptr <= !r_wptr;
            if (take) r_rptr <= !r_rptr;
            r_cnt <= r_cnt + 2'(acc) - 2'(take);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_VIEW_W: r_view_w <= i_cfg_data;
                    REG_VIEW_H: r_view_h <= i_cfg_data[VIEW_H_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

### rtl/cms_back.sv
`default_nettype none
module cms_back
    import cms_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int XW = $clog2(MAX_WIDTH),
    parameter int YW = $clog2(MAX_HEIGHT),
    parameter int EW = $clog2(MAX_WIDTH + 1),
    parameter int DW = $clog2(STACK_DEPTH + 1),
    parameter int AW = $clog2(STACK_DEPTH * MAX_WIDTH * MAX_HEIGHT),
    parameter int RW = 1 + YW + XW + EW + COV_W + COLOR_W + 1 + DW + 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_take,
    input  wire t_ctl               i_ctl,
    input  wire logic [XW-1:0]      i_x,
    input  wire logic [YW-1:0]      i_y,
    input  wire logic [COV_W-1:0]   i_cov,
    input  wire logic [COLOR_W-1:0] i_color,
    input  wire logic               i_room2,
    output logic                    o_wr,
    output logic      [RW-1:0]      o_wdata,
    output logic                    o_ram_we,
    output logic      [AW-1:0]      o_ram_waddr,
    output logic      [COV_W-1:0]   o_ram_wdata,
    output logic      [AW-1:0]      o_ram_raddr_a,
    output logic      [AW-1:0]      o_ram_raddr_b,
    input  wire logic [COV_W-1:0]   i_ram_rdata_a,
    input  wire logic [COV_W-1:0]   i_ram_rdata_b
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int CW    = $clog2(CELLS);
    localparam int PW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_FLUSH  = 5'd1;
    localparam logic [4:0] S_EXEC   = 5'd2;
    localparam logic [4:0] S_CLEAR  = 5'd3;
    localparam logic [4:0] S_F_RD   = 5'd4;
    localparam logic [4:0] S_F_MUL  = 5'd5;
    localparam logic [4:0] S_F_DIV  = 5'd6;
    localparam logic [4:0] S_F_WR   = 5'd7;
    localparam logic [4:0] S_ACK    = 5'd8;
    localparam logic [4:0] S_PIX    = 5'd9;
    localparam logic [4:0] S_P_MUL  = 5'd10;
    localparam logic [4:0] S_P_DIV  = 5'd11;
    localparam logic [4:0] S_LVL    = 5'd12;
    localparam logic [4:0] S_D_WR   = 5'd13;
    localparam logic [4:0] S_RUN    = 5'd14;
    localparam logic [4:0] S_RUN2   = 5'd15;

    logic [4:0]             r_state, n_state;
    t_ctl                   r_ctl;
    logic [XW-1:0]          r_x;
    logic [YW-1:0]          r_y;
    logic [COV_W-1:0]       r_cov;
    logic [COLOR_W-1:0]     r_color;
    logic [STACK_DEPTH-1:0] r_applied, n_applied;
    logic [DW-1:0]          r_count, n_count;
    logic                   r_fail, n_fail;
    logic [CW-1:0]          r_cell, n_cell;
    logic [PW-1:0]          r_plane, n_plane;
    logic [15:0]            r_prod, n_prod;
    logic [COV_W-1:0]       r_lvl, n_lvl;
    logic                   r_in_span, n_in_span;
    logic [YW-1:0]          r_run_row, n_run_row;
    logic [XW-1:0]          r_run_begin, n_run_begin;
    logic [EW-1:0]          r_run_stop, n_run_stop;
    logic [COV_W-1:0]       r_run_level, n_run_level;
    logic [COLOR_W-1:0]     r_run_color, n_run_color;

    logic             src_v;
    logic [PW-1:0]    src_i;
    logic             dst_v;
    logic [PW-1:0]    dst_i;
    logic [CW-1:0]    pix_cell;
    logic [COV_W-1:0] mul_a;
    logic [COV_W-1:0] mul_b;
    logic [16:0]      sc_x;
    logic [33:0]      sc_p;
    logic [COV_W-1:0] sc_q;
    logic             brk;
    logic             emit_old;
    logic             emit_new;

    function automatic logic [AW-1:0] cell_addr(logic [PW-1:0] p, logic [CW-1:0] c);
        return AW'(AW'(p) * AW'(CELLS) + AW'(c));
    endfunction

    function automatic logic [RW-1:0] pack_run(logic [YW-1:0] row, logic [XW-1:0] start,
                                               logic [EW-1:0] stop, logic [COV_W-1:0] cov,
                                               logic [COLOR_W-1:0] color, logic fail,
                                               logic [DW-1:0] cnt, logic lst);
        return {KIND_RUN, row, start, stop, cov, color, fail, cnt, lst};
    endfunction

    assign src_v = (r_count != '0) && r_applied[PW'(r_count - DW'(1))];
    assign src_i = PW'(r_count - DW'(1));

    // innermost unapplied plane
    always_comb begin
        dst_v = 1'b0;
        dst_i = '0;
        for (int k = 0; k < STACK_DEPTH; k++) begin
            if ((DW'(k) < r_count) && !r_applied[k]) begin
                dst_v = 1'b1;
                dst_i = PW'(k);
            end
        end
    end

    assign pix_cell = CW'(CW'(r_y) * CW'(MAX_WIDTH) + CW'(r_x));

    assign mul_a = (r_state == S_P_MUL) ? r_cov : i_ram_rdata_a;
    assign mul_b = (r_state == S_P_MUL) ? i_ram_rdata_a : i_ram_rdata_b;
    assign sc_x  = 17'(r_prod) + ROUND;
    assign sc_p  = 34'(sc_x) * 34'(RECIP);
    assign sc_q  = COV_W'(sc_p >> RECIP_SHIFT);

    assign brk = r_in_span && ((r_y != r_run_row) || (EW'(r_x) != r_run_stop) ||
                               (r_lvl != r_run_level) || (r_color != r_run_color));
    assign emit_old = !(src_v && (r_run_level == '0));
    assign emit_new = r_ctl.span_end && !(src_v && (r_lvl == '0));

    always_comb begin
        case (r_state)
            S_F_RD:  o_ram_raddr_a = cell_addr(r_plane, r_cell);
            S_PIX:   o_ram_raddr_a = cell_addr(src_i, pix_cell);
            S_LVL:   o_ram_raddr_a = cell_addr(dst_i, pix_cell);
            default: o_ram_raddr_a = '0;
        endcase
    end
    assign o_ram_raddr_b = cell_addr(PW'(r_plane - PW'(1)), r_cell);

    always_comb begin
        n_state     = r_state;
        n_applied   = r_applied;
        n_count     = r_count;
        n_fail      = r_fail;
        n_cell      = r_cell;
        n_plane     = r_plane;
        n_prod      = r_prod;
        n_lvl       = r_lvl;
        n_in_span   = r_in_span;
        n_run_row   = r_run_row;
        n_run_begin = r_run_begin;
        n_run_stop  = r_run_stop;
        n_run_level = r_run_level;
        n_run_color = r_run_color;
        o_take      = 1'b0;
        o_wr        = 1'b0;
        o_wdata     = pack_run(r_run_row, r_run_begin, r_run_stop, r_run_level,
                               r_run_color, r_fail, r_count, 1'b0);
        o_ram_we    = 1'b0;
        o_ram_waddr = cell_addr(r_plane, r_cell);
        o_ram_wdata = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid && i_room2) begin
                    o_take  = 1'b1;
                    n_state = (i_ctl.cmd == CMD_PIXEL) ? S_PIX : S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_wr      = r_in_span && emit_old;
                n_in_span = 1'b0;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_ACK;
                case (r_ctl.cmd)
                    CMD_PUSH: begin
                        if (r_fail || (r_count >= DW'(STACK_DEPTH))) begin
                            n_fail = 1'b1;
                        end else begin
                            n_plane = PW'(r_count);
                            n_cell  = '0;
                            n_applied[PW'(r_count)] = 1'b0;
                            n_state = S_CLEAR;
                        end
                    end
                    CMD_APPLY: begin
                        if (!r_fail && (r_count != '0)) begin
                            if ((src_i != '0) && r_applied[PW'(src_i - PW'(1))]) begin
                                n_plane = src_i;
                                n_cell  = '0;
                                n_state = S_F_RD;
                            end else begin
                                n_applied[src_i] = 1'b1;
                            end
                        end
                    end
                    CMD_POP: begin
                        if (r_count != '0) n_count = r_count - DW'(1);
                    end
                    default: ;
                endcase
            end
            S_CLEAR: begin
                o_ram_we = 1'b1;
                n_cell   = r_cell + CW'(1);
                if (r_cell == CW'(CELLS - 1)) begin
                    n_count = r_count + DW'(1);
                    n_state = S_ACK;
                end
            end
            S_F_RD:  n_state = S_F_MUL;
            S_F_MUL: begin
                n_prod  = 16'(mul_a) * 16'(mul_b);
                n_state = S_F_DIV;
            end
            S_F_DIV: begin
                n_lvl   = sc_q;
                n_state = S_F_WR;
            end
            S_F_WR: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = r_lvl;
                n_cell      = r_cell + CW'(1);
                n_state     = S_F_RD;
                if (r_cell == CW'(CELLS - 1)) begin
                    n_applied[r_plane] = 1'b1;
                    n_state = S_ACK;
                end
            end
            S_ACK: begin
                o_wr    = 1'b1;
                o_wdata = {KIND_ACK, YW'(0), XW'(0), EW'(0), COV_W'(0), COLOR_W'(0),
                           r_fail, r_count, 1'b1};
                n_state = S_IDLE;
            end
            S_PIX: begin
                if (r_fail) begin
                    n_state = S_IDLE;
                end else if (!r_ctl.in_view) begin
                    if (r_ctl.span_end) begin
                        o_wr      = r_in_span && emit_old;
                        o_wdata   = pack_run(r_run_row, r_run_begin, r_run_stop,
                                             r_run_level, r_run_color, r_fail, r_count, 1'b1);
                        n_in_span = 1'b0;
                    end
                    n_state = S_IDLE;
                end else if (src_v) begin
                    n_state = S_P_MUL;
                end else begin
                    n_lvl   = r_cov;
                    n_state = S_LVL;
                end
            end
            S_P_MUL: begin
                n_prod  = 16'(mul_a) * 16'(mul_b);
                n_state = S_P_DIV;
            end
            S_P_DIV: begin
                n_lvl   = sc_q;
                n_state = S_LVL;
            end
            S_LVL:   n_state = dst_v ? S_D_WR : S_RUN;
            S_D_WR: begin
                o_ram_waddr = cell_addr(dst_i, pix_cell);
                o_ram_wdata = r_lvl;
                o_ram_we    = (r_lvl > i_ram_rdata_a);
                n_state     = S_IDLE;
            end
            S_RUN: begin
                if (brk) begin
                    o_wr    = emit_old;
                    o_wdata = pack_run(r_run_row, r_run_begin, r_run_stop, r_run_level,
                                       r_run_color, r_fail, r_count, !emit_new);
                end
                if (r_in_span && !brk) begin
                    n_run_stop = EW'(r_x) + EW'(1);
                end else begin
                    n_in_span   = 1'b1;
                    n_run_row   = r_y;
                    n_run_begin = r_x;
                    n_run_stop  = EW'(r_x) + EW'(1);
                    n_run_level = r_lvl;
                    n_run_color = r_color;
                end
                n_state = r_ctl.span_end ? S_RUN2 : S_IDLE;
            end
            S_RUN2: begin
                o_wr      = emit_old;
                o_wdata   = pack_run(r_run_row, r_run_begin, r_run_stop, r_run_level,
                                     r_run_color, r_fail, r_count, 1'b1);
                n_in_span = 1'b0;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_ctl   <= i_ctl;
            r_x     <= i_x;
            r_y     <= i_y;
            r_cov   <= i_cov;
            r_color <= i_color;
        end
        r_cell      <= n_cell;
        r_plane     <= n_plane;
        r_prod      <= n_prod;
        r_lvl       <= n_lvl;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_applied   <= '0;
            r_count     <= '0;
            r_fail      <= 1'b0;
            r_in_span   <= 1'b0;
            r_run_begin <= '0;
            r_run_stop  <= '0;
            r_run_level <= '0;
            r_run_color <= '0;
            r_run_row   <= '0;
        end else begin
            r_state     <= n_state;
            r_applied   <= n_applied;
            r_count     <= n_count;
            r_fail      <= n_fail;
            r_in_span   <= n_in_span;
            r_run_begin <= n_run_begin;
            r_run_stop  <= n_run_stop;
            r_run_level <= n_run_level;
            r_run_color <= n_run_color;
            r_run_row   <= n_run_row;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DW'(STACK_DEPTH))
        else $error("plane count above stack depth");

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (r_state == S_IDLE) && i_valid && i_room2)
        else $error("item taken outside idle");

    a_wr_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr |-> (r_state == S_FLUSH) || (r_state == S_ACK) || (r_state == S_PIX) ||
                 (r_state == S_RUN) || (r_state == S_RUN2))
        else $error("result written from a non-emitting state");

    a_ack_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACK) |=> (r_state == S_IDLE))
        else $error("acknowledge did not end the command");

    a_sweep_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (DW'(r_plane) == r_count))
        else $error("clear sweep not on the new plane");
`endif

endmodule
`default_nettype wire

### rtl/coverage_mask_stack.sv
// span pixel: taken only in idle once the last one is done and the result queue has room,
//   then passed through the serial read, scale and merge steps of the back sequencer on the plane memory
// push: one plane cell cleared a cycle
// apply with fold: every plane cell goes through read, multiply, scale and write
// pop and plain apply: flush, execute and acknowledge; a two-entry input queue and four-entry result queue
// reset is synchronous active low; plane memory is not cleared, push clears its plane
`default_nettype none
module coverage_mask_stack
    import cms_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int XW = $clog2(MAX_WIDTH),
    parameter int YW = $clog2(MAX_HEIGHT),
    parameter int EW = $clog2(MAX_WIDTH + 1),
    parameter int DW = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [1:0]           i_command,
    input  wire logic [POS_W-1:0]     i_row,
    input  wire logic [POS_W-1:0]     i_column,
    input  wire logic [COV_W-1:0]     i_coverage,
    input  wire logic [COLOR_W-1:0]   i_color,
    input  wire logic                 i_span_end,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output logic                      empty,
    input  wire logic                 pop,
    output logic                      o_kind,
    output logic      [YW-1:0]        o_out_row,
    output logic      [XW-1:0]        o_start_column,
    output logic      [EW-1:0]        o_end_column,
    output logic      [COV_W-1:0]     o_out_coverage,
    output logic      [COLOR_W-1:0]   o_out_color,
    output logic                      o_failed_flag,
    output logic      [DW-1:0]        o_stack_depth,
    output logic                      o_last
);

    localparam int DEPTH = STACK_DEPTH * MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = 1 + YW + XW + EW + COV_W + COLOR_W + 1 + DW + 1;

    logic               f_valid;
    logic               b_take;
    t_ctl               f_ctl;
    logic [XW-1:0]      f_x;
    logic [YW-1:0]      f_y;
    logic [COV_W-1:0]   f_cov;
    logic [COLOR_W-1:0] f_color;
    logic               q_room2;
    logic               q_wr;
    logic [RW-1:0]      q_wdata;
    logic [RW-1:0]      q_data;
    logic               m_we;
    logic [AW-1:0]      m_waddr;
    logic [COV_W-1:0]   m_wdata;
    logic [AW-1:0]      m_raddr_a;
    logic [AW-1:0]      m_raddr_b;
    logic [COV_W-1:0]   m_rdata_a;
    logic [COV_W-1:0]   m_rdata_b;

    cms_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .XW(XW), .YW(YW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .o_full(full),
        .i_command(i_command), .i_row(i_row), .i_column(i_column),
        .i_coverage(i_coverage), .i_color(i_color), .i_span_end(i_span_end),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(f_valid), .i_take(b_take), .o_ctl(f_ctl),
        .o_x(f_x), .o_y(f_y), .o_cov(f_cov), .o_color(f_color)
    );

    cms_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .STACK_DEPTH(STACK_DEPTH),
        .XW(XW), .YW(YW), .EW(EW), .DW(DW), .AW(AW), .RW(RW)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_take(b_take), .i_ctl(f_ctl),
        .i_x(f_x), .i_y(f_y), .i_cov(f_cov), .i_color(f_color),
        .i_room2(q_room2), .o_wr(q_wr), .o_wdata(q_wdata),
        .o_ram_we(m_we), .o_ram_waddr(m_waddr), .o_ram_wdata(m_wdata),
        .o_ram_raddr_a(m_raddr_a), .o_ram_raddr_b(m_raddr_b),
        .i_ram_rdata_a(m_rdata_a), .i_ram_rdata_b(m_rdata_b)
    );

    cms_ram #(
        .W(COV_W), .DEPTH(DEPTH), .AW(AW)
    ) u_planes (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr_a(m_raddr_a), .i_raddr_b(m_raddr_b),
        .o_rdata_a(m_rdata_a), .o_rdata_b(m_rdata_b)
    );

    cms_outq #(
        .W(RW)
    ) u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr(q_wr), .i_wdata(q_wdata), .i_pop(pop),
        .o_empty(empty), .o_room2(q_room2), .o_data(q_data)
    );

    assign {o_kind, o_out_row, o_start_column, o_end_column, o_out_coverage,
            o_out_color, o_failed_flag, o_stack_depth, o_last} = q_data;

endmodule
`default_nettype wire

### dv/tb_coverage_mask_stack.sv
`timescale 1ns / 1ps
module tb_coverage_mask_stack;
    import cms_pkg::*;

    localparam int PW        = 256;
    localparam int PH        = 128;
    localparam int DEPTH     = 4;
    localparam int CELLS     = PW * PH;
    localparam int LIMIT     = 5_000_000;
    localparam int PHASES    = 5;
    localparam int PER_PHASE = 350;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [7:0]  cov;
        logic [31:0] color;
        logic        send;
    } stim_t;

    typedef struct packed {
        logic        kind;
        logic [6:0]  row;
        logic [7:0]  start;
        logic [8:0]  stop;
        logic [7:0]  cov;
        logic [31:0] color;
        logic        failed;
        logic [2:0]  depth;
        logic        last;
    } res_t;

    typedef struct packed {
        stim_t s;
        logic  typed;
        res_t  r;
    } dir_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [1:0]  i_command = CMD_PIXEL;
    logic [9:0]  i_row = '0;
    logic [9:0]  i_column = '0;
    logic [7:0]  i_coverage = '0;
    logic [31:0] i_color = '0;
    logic        i_span_end = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_VIEW_W;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    wire         full, empty;
    wire         o_kind, o_failed_flag, o_last;
    wire [6:0]   o_out_row;
    wire [7:0]   o_start_column;
    wire [8:0]   o_end_column;
    wire [7:0]   o_out_coverage;
    wire [31:0]  o_out_color;
    wire [2:0]   o_stack_depth;

    coverage_mask_stack u_top (
        .i_clk, .i_rst_n, .push, .full, .i_command, .i_row, .i_column, .i_coverage,
        .i_color, .i_span_end, .i_cfg_we, .i_cfg_index, .i_cfg_data, .empty, .pop,
        .o_kind, .o_out_row, .o_start_column, .o_end_column, .o_out_coverage,
        .o_out_color, .o_failed_flag, .o_stack_depth, .o_last
    );

    always #5 i_clk = ~i_clk;

    int unsigned cycles;
    int          errors;
    int          n_got;
    bit          quiet;
    res_t        expected_q[$];

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_coverage_mask_stack: FAIL");
            $finish;
        end
    end

    // mirror of the block state
    byte unsigned planes[DEPTH*CELLS];
    bit          applied[DEPTH];
    int          plane_cnt;
    bit          failed;
    bit          in_span;
    int          run_row, run_begin, run_stop, run_level;
    logic [31:0] run_color;
    int          view_w = 256, view_h = 128;
    int          push_budget = 6, fold_budget = 1;

    function automatic int eff_w();
        return view_w < 1 ? 1 : (view_w > PW ? PW : view_w);
    endfunction

    function automatic int eff_h();
        return view_h < 1 ? 1 : (view_h > PH ? PH : view_h);
    endfunction

    function automatic int blend(int a, int b);
        return (a * b + 127) / 255;
    endfunction

    function automatic bit top_applied();
        return plane_cnt > 0 && applied[plane_cnt-1];
    endfunction

    // an apply that folds blends every cell of the top plane with the plane below it
    function automatic bit apply_folds();
        return !failed && plane_cnt > 1 && applied[plane_cnt-2];
    endfunction

    function automatic res_t make_res(logic kind, int row, int start, int stop, int cov,
                                      logic [31:0] color);
        res_t r;
        r.kind = kind; r.row = 7'(row); r.start = 8'(start); r.stop = 9'(stop);
        r.cov = 8'(cov);
        r.color = color; r.failed = failed; r.depth = 3'(plane_cnt); r.last = 1'b0;
        return r;
    endfunction

    task automatic flush_run(ref res_t outs[$]);
        if (in_span) begin
            if (!(top_applied() && run_level == 0))
                outs.push_back(make_res(KIND_RUN, run_row, run_begin, run_stop, run_level,
                                        run_color));
            in_span = 0;
        end
    endtask

    task automatic predict_runs(input stim_t s, output res_t outs[$]);
        int y, x, pix, level, dst;
        y = $signed(s.row);
        x = $signed(s.col);
        outs = {};
        if (s.cmd != CMD_PIXEL) begin
            flush_run(outs);
            case (s.cmd)
                CMD_PUSH: begin
                    if (failed || plane_cnt >= DEPTH) failed = 1;
                    else begin
                        for (int i = 0; i < CELLS; i++) planes[plane_cnt*CELLS+i] = 0;
                        applied[plane_cnt] = 0;
                        plane_cnt++;
                    end
                end
                CMD_APPLY: begin
                    if (!failed && plane_cnt > 0) begin
                        if (apply_folds())
                            for (int i = 0; i < CELLS; i++)
                                planes[(plane_cnt-1)*CELLS+i] =
                                    8'(blend(planes[(plane_cnt-1)*CELLS+i],
                                             planes[(plane_cnt-2)*CELLS+i]));
                        applied[plane_cnt-1] = 1;
                    end
                end
                default: if (plane_cnt > 0) plane_cnt--;
            endcase
            outs.push_back(make_res(KIND_ACK, 0, 0, 0, 0, 0));
        end else if (!failed) begin
            if (y < 0 || y >= eff_h() || x < 0 || x >= eff_w()) begin
                if (s.send) flush_run(outs);
            end else begin
                pix = y * PW + x;
                level = top_applied() ? blend(s.cov, planes[(plane_cnt-1)*CELLS+pix])
                                      : int'(s.cov);
                dst = -1;
                for (int k = plane_cnt - 1; k >= 0 && dst < 0; k--)
                    if (!applied[k]) dst = k;
                if (dst >= 0) begin
                    if (level > planes[dst*CELLS+pix]) planes[dst*CELLS+pix] = 8'(level);
                end else begin
                    if (in_span && (y != run_row || x != run_stop || level != run_level ||
                                    s.color != run_color))
                        flush_run(outs);
                    if (!in_span) begin
                        in_span = 1; run_row = y; run_begin = x;
                        run_level = level; run_color = s.color;
                    end
                    run_stop = x + 1;
                    if (s.send) flush_run(outs);
                end
            end
        end
        if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    endtask

    task automatic report(string field, int got, int want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, field, got, want);
        errors++;
    endtask

    // result side: checks each transaction, stalls in bursts and once for a long stretch
    initial begin
        res_t e;
        int idle_left, hold_left;
        bit held;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                n_got++;
                if (expected_q.size() == 0) report("unexpected result kind", o_kind, 0);
                else begin
                    e = expected_q.pop_front();
                    if (o_kind !== e.kind) report("kind", o_kind, e.kind);
                    if (o_out_row !== e.row) report("out_row", o_out_row, e.row);
                    if (o_start_column !== e.start) report("start_column", o_start_column, e.start);
                    if (o_end_column !== e.stop) report("end_column", o_end_column, e.stop);
                    if (o_out_coverage !== e.cov) report("out_coverage", o_out_coverage, e.cov);
                    if (o_out_color !== e.color) report("out_color", o_out_color, e.color);
                    if (o_failed_flag !== e.failed) report("failed_flag", o_failed_flag, e.failed);
                    if (o_stack_depth !== e.depth) report("stack_depth", o_stack_depth, e.depth);
                    if (o_last !== e.last) report("last", o_last, e.last);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (!held && n_got >= 200) begin
                held = 1;
                hold_left = 500;
                pop <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                idle_left = $urandom_range(0, 6);
                pop <= 1'b0;
            end else begin
                pop <= i_rst_n;
            end
        end
    end

    task automatic send(input stim_t s, input bit typed, input res_t fixed);
        res_t outs[$];
        push <= 1'b1;
        i_command <= s.cmd; i_row <= s.row; i_column <= s.col;
        i_coverage <= s.cov; i_color <= s.color; i_span_end <= s.send;
        do @(posedge i_clk); while (full);
        predict_runs(s, outs);
        if (typed) outs = '{fixed};
        foreach (outs[i]) expected_q.push_back(outs[i]);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_cmd(input logic [1:0] cmd);
        stim_t s;
        s = '0;
        s.cmd = cmd;
        s.row = 10'($urandom); s.col = 10'($urandom); s.cov = 8'($urandom);
        s.color = $urandom;
        s.send = 1'($urandom);
        send(s, 1'b0, '0);
    endtask

    // pixel acceptance may write the plane without any result, so allow it to settle
    task automatic drain();
        push <= 1'b0;
        while (expected_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_VIEW_W) view_w = value & 9'h1FF;
        else view_h = value & 8'hFF;
    endtask

    task automatic random_traffic(input int count);
        stim_t s;
        int sent, len, hi_r, hi_c, r;
        bit flat;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 6) begin
                r = $urandom_range(0, 2);
                if (r == 0 && push_budget > 0 && plane_cnt < DEPTH) begin
                    push_budget--;
                    send_cmd(CMD_PUSH);
                end else if (r == 1 && (!apply_folds() || fold_budget > 0)) begin
                    if (apply_folds()) fold_budget--;
                    send_cmd(CMD_APPLY);
                end else begin
                    send_cmd(CMD_POP);
                end
                sent++;
            end else begin
                hi_r = eff_h() < 8 ? eff_h() : 8;
                hi_c = eff_w() < 32 ? eff_w() : 32;
                len = $urandom_range(1, 10);
                flat = $urandom_range(0, 1);
                s.cmd = CMD_PIXEL;
                s.row = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, hi_r-1));
                s.col = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, hi_c-1));
                s.color = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 1)) : 32'($urandom);
                s.cov = $urandom_range(0, 3) == 0 ? 8'(255 * $urandom_range(0, 1)) : 8'($urandom);
                for (int i = 0; i < len; i++) begin
                    if (!flat) s.cov = 8'($urandom);
                    if ($urandom_range(0, 19) == 0) s.color = $urandom;
                    s.send = (i == len - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
                    send(s, 1'b0, '0);
                    s.col = 10'(s.col + (($urandom_range(0, 9) == 0) ? 2 : 1));
                    sent++;
                end
            end
        end
    endtask

    dir_t directed[] = '{
        '{'{CMD_PIXEL, 10'd0, 10'd0, 8'd255, 32'hA5A5_0001, 1'b1}, 1'b1,
          '{KIND_RUN, 7'd0, 8'd0, 9'd1, 8'd255, 32'hA5A5_0001, 1'b0, 3'd0, 1'b1}},
        '{'{CMD_PIXEL, 10'd127, 10'd255, 8'd0, 32'hFFFF_FFFF, 1'b1}, 1'b1,
          '{KIND_RUN, 7'd127, 8'd255, 9'd256, 8'd0, 32'hFFFF_FFFF, 1'b0, 3'd0, 1'b1}},
        '{'{CMD_PIXEL, 10'd5, 10'd10, 8'd80, 32'h0000_0000, 1'b0}, 1'b0, '0},
        '{'{CMD_PIXEL, 10'h200, 10'd0, 8'd1, 32'h1, 1'b0}, 1'b0, '0},
        '{'{CMD_PIXEL, 10'd5, 10'd11, 8'd80, 32'h0000_0000, 1'b0}, 1'b0, '0},
        '{'{CMD_PIXEL, 10'd5, 10'd12, 8'd90, 32'h0000_0000, 1'b0}, 1'b0, '0},
        '{'{CMD_PIXEL, 10'd5, 10'd14, 8'd90, 32'h0000_0000, 1'b0}, 1'b0, '0},
        '{'{CMD_PIXEL, 10'd511, 10'h3FF, 8'd7, 32'h7, 1'b1}, 1'b0, '0},
        '{'{CMD_POP, 10'd0, 10'd0, 8'd0, 32'h0, 1'b0}, 1'b1,
          '{KIND_ACK, 7'd0, 8'd0, 9'd0, 8'd0, 32'h0, 1'b0, 3'd0, 1'b1}},
        '{'{CMD_APPLY, 10'd0, 10'd0, 8'd0, 32'h0, 1'b0}, 1'b1,
          '{KIND_ACK, 7'd0, 8'd0, 9'd0, 8'd0, 32'h0, 1'b0, 3'd0, 1'b1}},
        '{'{CMD_PIXEL, 10'd6, 10'd3, 8'd40, 32'h1234_5678, 1'b0}, 1'b0, '0},
        '{'{CMD_PUSH, 10'd0, 10'd0, 8'd0, 32'h0, 1'b0}, 1'b0, '0},
        '{'{CMD_PIXEL, 10'd10, 10'd20, 8'd200, 32'h1, 1'b0}, 1'b0, '0},
        '{'{CMD_PIXEL, 10'd10, 10'd20, 8'd100, 32'h1, 1'b0}, 1'b0, '0},
        '{'{CMD_PIXEL, 10'd10, 10'd21, 8'd255, 32'h1, 1'b1}, 1'b0, '0},
        '{'{CMD_APPLY, 10'd0, 10'd0, 8'd0, 32'h0, 1'b0}, 1'b1,
          '{KIND_ACK, 7'd0, 8'd0, 9'd0, 8'd0, 32'h0, 1'b0, 3'd1, 1'b1}},
        '{'{CMD_PIXEL, 10'd10, 10'd20, 8'd255, 32'h2, 1'b0}, 1'b0, '0},
        '{'{CMD_PIXEL, 10'd10, 10'd21, 8'd255, 32'h2, 1'b0}, 1'b0, '0},
        '{'{CMD_PIXEL, 10'd10, 10'd22, 8'd255, 32'h2, 1'b1}, 1'b0, '0},
        '{'{CMD_PUSH, 10'd0, 10'd0, 8'd0, 32'h0, 1'b0}, 1'b1,
          '{KIND_ACK, 7'd0, 8'd0, 9'd0, 8'd0, 32'h0, 1'b0, 3'd2, 1'b1}},
        '{'{CMD_PIXEL, 10'd10, 10'd20, 8'd255, 32'h3, 1'b0}, 1'b0, '0},
        '{'{CMD_PIXEL, 10'd10, 10'd21, 8'd128, 32'h3, 1'b1}, 1'b0, '0},
        '{'{CMD_APPLY, 10'd0, 10'd0, 8'd0, 32'h0, 1'b0}, 1'b0, '0},
        '{'{CMD_PIXEL, 10'd10, 10'd20, 8'd255, 32'h4, 1'b0}, 1'b0, '0},
        '{'{CMD_PIXEL, 10'd10, 10'd21, 8'd255, 32'h4, 1'b1}, 1'b0, '0}
    };

    int w_tab[PHASES] = '{256, 0, 511, 37, 256};
    int h_tab[PHASES] = '{128, 0, 255, 9, 128};

    initial begin
        stim_t s;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < PHASES; p++) begin
            write_reg(REG_VIEW_W, w_tab[p]);
            write_reg(REG_VIEW_H, h_tab[p]);
            if (p == 0)
                foreach (directed[i]) send(directed[i].s, directed[i].typed, directed[i].r);
            if (p == PHASES - 1) quiet = 1;
            random_traffic(PER_PHASE);
            drain();
        end
        // fill the stack, overflow it, then confirm the sticky failure
        while (plane_cnt < DEPTH) send_cmd(CMD_PUSH);
        send_cmd(CMD_PUSH);
        s = '{CMD_PIXEL, 10'd1, 10'd1, 8'd200, 32'hDEAD_BEEF, 1'b1};
        send(s, 1'b0, '0);
        send_cmd(CMD_APPLY);
        send_cmd(CMD_POP);
        send_cmd(CMD_POP);
        drain();
        if (errors == 0) begin
            $display("tb_coverage_mask_stack: PASS");
        end else begin
            $display("tb_coverage_mask_stack: FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/cms_pkg.sv
rtl/cms_ram.sv
rtl/cms_outq.sv
rtl/cms_front.sv
rtl/cms_back.sv
rtl/coverage_mask_stack.sv
dv/tb_coverage_mask_stack.sv
